// ----- design/tbpf_pkg.sv -----
// Shared types and constants for the tile background pixel fetch block.
package tbpf_pkg;

  // Video memory geometry
  localparam int unsigned MemoryBytes = 16384;
  localparam int unsigned AddrW       = 14;
  localparam int unsigned DataW       = 8;

  // Input command codes
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_PIXEL = 1'b1;

  // Configuration register indexes
  localparam logic CFG_PATTERN_SEL = 1'b0;
  localparam logic CFG_NAME_SEL    = 1'b1;

  // One access to the single-port video memory
  typedef struct packed {
    logic             we;
    logic             re;
    logic [AddrW-1:0] addr;
    logic [DataW-1:0] wdata;
  } ram_req_t;

  // Finished pixel handed from the sequencer to the output register
  typedef struct packed {
    logic       valid;
    logic [3:0] palette_index;
    logic [7:0] x;
    logic [7:0] y;
  } res_t;

endpackage

// ----- design/tbpf_ram.sv -----
// Generic single-port synchronous RAM with registered read data.
module tbpf_ram #(
  parameter int unsigned Depth = 16384,
  parameter int unsigned Width = 8,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [Width-1:0] wdata_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  // Writes beyond the populated depth are dropped
  always_ff @(posedge clk_i) begin
    if (we_i && (32'(addr_i) < Depth)) begin
      mem[addr_i] <= wdata_i;
    end
  end

  // Read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/tbpf_seq.sv -----
// Fetch sequencer: walks name, attribute and both bitplane reads per pixel.
module tbpf_seq (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     in_cmd_i,
  input  logic [13:0]              in_mem_address_i,
  input  logic [7:0]               in_mem_byte_i,
  input  logic [7:0]               in_pixel_x_i,
  input  logic [7:0]               in_pixel_y_i,
  input  logic                     pattern_sel_i,
  input  logic [1:0]               name_sel_i,
  output tbpf_pkg::ram_req_t       ram_req_o,
  input  logic [tbpf_pkg::DataW-1:0] ram_rdata_i,
  output tbpf_pkg::res_t           res_o,
  input  logic                     res_ready_i
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_ATTR = 3'd1;
  localparam logic [2:0] ST_P0   = 3'd2;
  localparam logic [2:0] ST_P1   = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0] state_q, state_d;
  logic [7:0] x_q, y_q;
  logic [7:0] tile_q;
  logic [1:0] quad_q;
  logic [7:0] plane0_q;
  logic       pix_accept;

  // Name table entry: 0x2000 + sel*0x400 + row*32 + col
  function automatic logic [13:0] name_addr(logic [1:0] sel, logic [7:0] px, logic [7:0] py);
    name_addr = {2'b10, sel, py[7:3], px[7:3]};
  endfunction

  // Attribute byte: 0x2000 + sel*0x400 + 0x3C0 + (row/4)*8 + col/4
  function automatic logic [13:0] attr_addr(logic [1:0] sel, logic [7:0] px, logic [7:0] py);
    attr_addr = {2'b10, sel, 4'b1111, py[7:5], px[7:5]};
  endfunction

  // Pattern row: sel*0x1000 + tile*16 + plane*8 + fine_y
  function automatic logic [13:0] pat_addr(logic sel, logic [7:0] tile, logic plane,
                                           logic [2:0] fy);
    pat_addr = {1'b0, sel, tile, plane, fy};
  endfunction

  assign in_stall_o = (state_q != ST_IDLE);
  assign pix_accept = in_valid_i && (state_q == ST_IDLE) && (in_cmd_i == tbpf_pkg::CMD_PIXEL);

  // Memory request per state
  always_comb begin
    ram_req_o       = '0;
    ram_req_o.wdata = in_mem_byte_i;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (in_cmd_i == tbpf_pkg::CMD_WRITE) begin
            ram_req_o.we   = 1'b1;
            ram_req_o.addr = in_mem_address_i;
          end else begin
            ram_req_o.re   = 1'b1;
            ram_req_o.addr = name_addr(name_sel_i, in_pixel_x_i, in_pixel_y_i);
          end
        end
      end
      ST_ATTR: begin
        ram_req_o.re   = 1'b1;
        ram_req_o.addr = attr_addr(name_sel_i, x_q, y_q);
      end
      ST_P0: begin
        ram_req_o.re   = 1'b1;
        ram_req_o.addr = pat_addr(pattern_sel_i, tile_q, 1'b0, y_q[2:0]);
      end
      ST_P1: begin
        ram_req_o.re   = 1'b1;
        ram_req_o.addr = pat_addr(pattern_sel_i, tile_q, 1'b1, y_q[2:0]);
      end
      default: begin
      end
    endcase
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (pix_accept) state_d = ST_ATTR;
      ST_ATTR: state_d = ST_P0;
      ST_P0:   state_d = ST_P1;
      ST_P1:   state_d = ST_DONE;
      ST_DONE: if (res_ready_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Capture coordinates and read data as it returns
  always_ff @(posedge clk_i) begin
    if (pix_accept) begin
      x_q <= in_pixel_x_i;
      y_q <= in_pixel_y_i;
    end
    if (state_q == ST_ATTR) begin
      tile_q <= ram_rdata_i;
    end
    if (state_q == ST_P0) begin
      // quadrant picked by bit 1 of tile row and tile column
      case ({y_q[4], x_q[4]})
        2'b00:   quad_q <= ram_rdata_i[1:0];
        2'b01:   quad_q <= ram_rdata_i[3:2];
        2'b10:   quad_q <= ram_rdata_i[5:4];
        default: quad_q <= ram_rdata_i[7:6];
      endcase
    end
    if (state_q == ST_P1) begin
      plane0_q <= ram_rdata_i;
    end
  end

  // Bitplane 1 sits on the read port while the result waits
  assign res_o.valid         = (state_q == ST_DONE);
  assign res_o.palette_index = {quad_q, ram_rdata_i[~x_q[2:0]], plane0_q[~x_q[2:0]]};
  assign res_o.x             = x_q;
  assign res_o.y             = y_q;

endmodule

// ----- design/tile_background_pixel_fetch.sv -----
// Top level: config registers, video memory, fetch sequencer and output register.
// A memory write is taken every cycle the sequencer is idle; a pixel moves through
// ATTR, P0, P1 and DONE, and the next item waits until DONE hands it to the output
// register: four dependent reads on the single memory port plus the hand-off.
// A stalled output register holds the finished pixel in the sequencer and blocks input.
// Reset clears config registers and control state; video memory is not cleared.
module tile_background_pixel_fetch (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        in_cmd_i,
  input  logic [13:0] in_mem_address_i,
  input  logic [7:0]  in_mem_byte_i,
  input  logic [7:0]  in_pixel_x_i,
  input  logic [7:0]  in_pixel_y_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  out_palette_index_o,
  output logic [7:0]  out_x_o,
  output logic [7:0]  out_y_o,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [1:0]  cfg_data_i
);

  logic                        pattern_sel_q;
  logic [1:0]                  name_sel_q;
  tbpf_pkg::ram_req_t          ram_req;
  logic [tbpf_pkg::DataW-1:0]  ram_rdata;
  tbpf_pkg::res_t              res;
  logic                        res_ready;
  logic                        out_valid_q;
  logic [3:0]                  palette_q;
  logic [7:0]                  x_q, y_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_sel_q <= 1'b0;
      name_sel_q    <= 2'b00;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        tbpf_pkg::CFG_PATTERN_SEL: pattern_sel_q <= cfg_data_i[0];
        tbpf_pkg::CFG_NAME_SEL:    name_sel_q    <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  tbpf_ram #(
    .Depth(tbpf_pkg::MemoryBytes),
    .Width(tbpf_pkg::DataW),
    .AddrW(tbpf_pkg::AddrW)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_req.we),
    .re_i   (ram_req.re),
    .addr_i (ram_req.addr),
    .wdata_i(ram_req.wdata),
    .rdata_o(ram_rdata)
  );

  tbpf_seq u_seq (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .in_cmd_i        (in_cmd_i),
    .in_mem_address_i(in_mem_address_i),
    .in_mem_byte_i   (in_mem_byte_i),
    .in_pixel_x_i    (in_pixel_x_i),
    .in_pixel_y_i    (in_pixel_y_i),
    .pattern_sel_i   (pattern_sel_q),
    .name_sel_i      (name_sel_q),
    .ram_req_o       (ram_req),
    .ram_rdata_i     (ram_rdata),
    .res_o           (res),
    .res_ready_i     (res_ready)
  );

  // Output register: free when empty or being drained this cycle
  assign res_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid && res_ready) begin
      palette_q <= res.palette_index;
      x_q       <= res.x;
      y_q       <= res.y;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign out_palette_index_o = palette_q;
  assign out_x_o             = x_q;
  assign out_y_o             = y_q;

  // Single memory port: never a read and a write together
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_req.we && ram_req.re))
    else $error("memory read and write in the same cycle");

  // A pixel transfer occupies the sequencer on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && in_cmd_i == tbpf_pkg::CMD_PIXEL) |=> in_stall_o)
    else $error("sequencer free right after a pixel transfer");

  // A finished pixel waits while the output register is full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res.valid && !res_ready) |=> (res.valid && $stable(res.palette_index)))
    else $error("pending result dropped or changed");

  // No new result is offered while the sequencer accepts input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.valid |-> in_stall_o)
    else $error("result pending while input is open");

endmodule
